/* rtl/assert_macros.svh */
// assertion helpers for the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every enabled clock edge
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/agraph_pkg.sv */
`timescale 1ns / 1ps

package agraph_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int ROW_W        = MAX_VERTICES;
    localparam int VERT_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int OP_W         = 3;
    localparam int REC_CNT_W    = 4;
    localparam int MAX_RECS     = 14;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd2;
    localparam logic [OP_W-1:0] OP_DEGREE    = 3'd3;
    localparam logic [OP_W-1:0] OP_RECOMMEND = 3'd4;

    // row read address select
    localparam logic [1:0] SEL_U  = 2'd0;
    localparam logic [1:0] SEL_V  = 2'd1;
    localparam logic [1:0] SEL_NB = 2'd2;

    typedef struct packed {
        logic       latch_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_sel_v;
        logic       load_u;
        logic       load_nb;
        logic       emit_rec;
        logic       emit_final;
    } agraph_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            known;
        logic            bad;
        logic            pend_empty;
        logic            cand_empty;
        logic            rec_full;
        logic            out_free;
    } agraph_status_t;

    function automatic logic [VERT_W-1:0] lowest_index(input logic [ROW_W-1:0] row);
        logic [VERT_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (row[i]) begin
                idx = VERT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [ROW_W-1:0] onehot(input logic [VERT_W-1:0] idx);
        return ROW_W'(1) << idx;
    endfunction

endpackage

/* rtl/agraph_ctrl.sv */
`timescale 1ns / 1ps

module agraph_ctrl
    import agraph_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  agraph_status_t status,
    output agraph_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_WR_U    = 4'd2;
    localparam logic [3:0] S_RD_V    = 4'd3;
    localparam logic [3:0] S_WR_V    = 4'd4;
    localparam logic [3:0] S_LOAD_U  = 4'd5;
    localparam logic [3:0] S_NEXT_NB = 4'd6;
    localparam logic [3:0] S_LOAD_NB = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;
    localparam logic [3:0] S_FINAL   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!status.known || status.bad) begin
                    state_next = S_FINAL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_U;
                    case (status.op)
                        OP_INSERT, OP_REMOVE: state_next = S_WR_U;
                        OP_RECOMMEND:         state_next = S_LOAD_U;
                        default:              state_next = S_FINAL;
                    endcase
                end
            end
            S_WR_U: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel_v = 1'b0;
                state_next   = S_RD_V;
            end
            S_RD_V: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_V;
                state_next = S_WR_V;
            end
            S_WR_V: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel_v = 1'b1;
                state_next   = S_FINAL;
            end
            S_LOAD_U: begin
                cmd.load_u = 1'b1;
                state_next = S_NEXT_NB;
            end
            S_NEXT_NB: begin
                if (status.pend_empty) begin
                    state_next = S_FINAL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_NB;
                    state_next = S_LOAD_NB;
                end
            end
            S_LOAD_NB: begin
                cmd.load_nb = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (status.cand_empty) begin
                    state_next = S_NEXT_NB;
                end else if (status.rec_full) begin
                    state_next = S_FINAL;
                end else if (status.out_free) begin
                    cmd.emit_rec = 1'b1;
                end
            end
            S_FINAL: begin
                if (status.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/agraph_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module agraph_datapath
    import agraph_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [COUNT_W-1:0]  n_eff,
    input  logic [OP_W-1:0]     op_in,
    input  logic [VERT_W-1:0]   u_in,
    input  logic [VERT_W-1:0]   v_in,
    input  agraph_cmd_t         cmd,
    output agraph_status_t      status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_edge,
    output logic [COUNT_W-1:0]  out_degree,
    output logic [VERT_W-1:0]   out_vertex,
    output logic                out_vvalid,
    output logic                out_last,
    output logic                out_bad
);

    // item fields
    logic [OP_W-1:0]   op_reg;
    logic [VERT_W-1:0] u_reg;
    logic [VERT_W-1:0] v_reg;

    // row store, valid bits stand for the cleared matrix
    logic [ROW_W-1:0]  rows_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [ROW_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic [ROW_W-1:0]  rd_row;
    logic [VERT_W-1:0] rd_addr;
    logic [VERT_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic [ROW_W-1:0]  wr_bit;

    // recommend state
    logic [ROW_W-1:0]     urow_reg;
    logic [ROW_W-1:0]     pend_reg;
    logic [ROW_W-1:0]     cand_reg;
    logic [ROW_W-1:0]     seen_reg;
    logic [REC_CNT_W-1:0] rec_cnt_reg;
    logic [ROW_W-1:0]     new_cand;
    logic [VERT_W-1:0]    nb_idx;
    logic [VERT_W-1:0]    cand_idx;

    logic [ROW_W-1:0]   nmask;
    logic [COUNT_W-1:0] degree;
    logic               uses_v;
    logic               item_ok;

    logic                out_valid_reg;
    logic                out_edge_reg;
    logic [COUNT_W-1:0]  out_degree_reg;
    logic [VERT_W-1:0]   out_vertex_reg;
    logic                out_vvalid_reg;
    logic                out_last_reg;
    logic                out_bad_reg;

    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            nmask[i] = (COUNT_W'(i) < n_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg <= op_in;
            u_reg  <= u_in;
            v_reg  <= v_in;
        end
    end

    assign uses_v        = (op_reg == OP_INSERT) || (op_reg == OP_REMOVE) || (op_reg == OP_QUERY);
    assign status.op     = op_reg;
    assign status.known  = (op_reg <= OP_RECOMMEND);
    assign status.bad    = ({1'b0, u_reg} >= n_eff) || (uses_v && ({1'b0, v_reg} >= n_eff));
    assign status.pend_empty = (pend_reg == '0);
    assign status.cand_empty = (cand_reg == '0);
    assign status.rec_full   = (rec_cnt_reg == REC_CNT_W'(MAX_RECS));
    assign status.out_free   = !out_valid_reg || out_ready;

    // known operation on in-range vertices
    assign item_ok = status.known && !status.bad;

    assign nb_idx   = lowest_index(pend_reg);
    assign cand_idx = lowest_index(cand_reg);

    always_comb begin
        case (cmd.rd_sel)
            SEL_U:   rd_addr = u_reg;
            SEL_V:   rd_addr = v_reg;
            SEL_NB:  rd_addr = nb_idx;
            default: rd_addr = u_reg;
        endcase
    end

    assign rd_row  = rd_valid_reg ? rd_data_reg : '0;
    assign wr_addr = cmd.wr_sel_v ? v_reg : u_reg;
    assign wr_bit  = onehot(cmd.wr_sel_v ? u_reg : v_reg);
    assign wr_data = (op_reg == OP_REMOVE) ? (rd_row & ~wr_bit) : (rd_row | wr_bit);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            rows_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= rows_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // candidates of one neighbor row, not yet seen
    assign new_cand = rd_row & ~urow_reg & ~onehot(u_reg) & ~seen_reg & nmask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            cand_reg    <= '0;
            seen_reg    <= '0;
            rec_cnt_reg <= '0;
        end else begin
            if (cmd.load_u) begin
                pend_reg    <= rd_row & nmask;
                cand_reg    <= '0;
                seen_reg    <= '0;
                rec_cnt_reg <= '0;
            end
            if (cmd.rd_en && (cmd.rd_sel == SEL_NB)) begin
                pend_reg <= pend_reg & ~onehot(nb_idx);
            end
            if (cmd.load_nb) begin
                cand_reg <= new_cand;
                seen_reg <= seen_reg | new_cand;
            end
            if (cmd.emit_rec) begin
                cand_reg    <= cand_reg & ~onehot(cand_idx);
                rec_cnt_reg <= rec_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_u) begin
            urow_reg <= rd_row;
        end
    end

    always_comb begin
        degree = '0;
        for (int i = 0; i < ROW_W; i++) begin
            degree = degree + COUNT_W'(rd_row[i] & nmask[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_rec || cmd.emit_final) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_rec) begin
            out_edge_reg   <= 1'b0;
            out_degree_reg <= '0;
            out_vertex_reg <= cand_idx;
            out_vvalid_reg <= 1'b1;
            out_last_reg   <= 1'b0;
            out_bad_reg    <= 1'b0;
        end else if (cmd.emit_final) begin
            out_edge_reg   <= item_ok && (op_reg == OP_QUERY) && rd_row[v_reg];
            out_degree_reg <= (item_ok && (op_reg == OP_DEGREE)) ? degree : '0;
            out_vertex_reg <= '0;
            out_vvalid_reg <= 1'b0;
            out_last_reg   <= 1'b1;
            out_bad_reg    <= status.known && status.bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_edge   = out_edge_reg;
    assign out_degree = out_degree_reg;
    assign out_vertex = out_vertex_reg;
    assign out_vvalid = out_vvalid_reg;
    assign out_last   = out_last_reg;
    assign out_bad    = out_bad_reg;

    `ASSERT_ALWAYS(a_rec_cap, aclk, aresetn, rec_cnt_reg <= REC_CNT_W'(MAX_RECS), "recommend count past cap")
    `ASSERT_IMPLIES(a_rec_not_last, aclk, aresetn, out_valid_reg && out_vvalid_reg, !out_last_reg, "recommendation marked last")
    `ASSERT_IMPLIES(a_bad_clean, aclk, aresetn, out_valid_reg && out_bad_reg, !out_vvalid_reg && !out_edge_reg && (out_degree_reg == '0), "bad vertex word carries data")
    `ASSERT_IMPLIES(a_rec_in_range, aclk, aresetn, out_valid_reg && out_vvalid_reg, {1'b0, out_vertex_reg} < n_eff, "recommended vertex out of range")

endmodule

/* rtl/adjacency_matrix_graph_engine.sv */
`timescale 1ns / 1ps
// order: query, degree, bad or unknown words go accept, check, final, then raise m_tvalid
// insert and remove add write u, read v, write v; recommend adds load u, then the scan
// items: one at a time, next word taken once the last result word has registered
// recommend time is set by the scan: each neighbor row costs a read, a load and an empty check
// reset: aresetn low clears the matrix (per-row valid bits), vertex_count back to 16

module adjacency_matrix_graph_engine
    import agraph_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[2:0], first_vertex[6:3], second_vertex[10:7]

    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // edge_present[0], degree_count[5:1], recommended_vertex[9:6]
    output logic [1:0]  m_tuser,   // vertex_valid[0], bad_vertex[1]
    output logic        m_tlast,   // last_of_run

    // vertex_count register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    logic [COUNT_W-1:0] vertex_count_reg;
    logic [COUNT_W-1:0] n_eff;

    agraph_cmd_t    cmd;
    agraph_status_t status;

    logic               out_edge;
    logic [COUNT_W-1:0] out_degree;
    logic [VERT_W-1:0]  out_vertex;
    logic               out_vvalid;
    logic               out_last;
    logic               out_bad;

    // config taken only while the sequencer is idle
    assign cfg_ready = s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= COUNT_W'(MAX_VERTICES);
        end else if (cfg_valid && cfg_ready) begin
            vertex_count_reg <= cfg_data;
        end
    end

    // clamp to the matrix size
    assign n_eff = (vertex_count_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                                : vertex_count_reg;

    // sequencer
    agraph_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // row store, recommend scan and output register
    agraph_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .n_eff      (n_eff),
        .op_in      (s_tdata[2:0]),
        .u_in       (s_tdata[6:3]),
        .v_in       (s_tdata[10:7]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_edge   (out_edge),
        .out_degree (out_degree),
        .out_vertex (out_vertex),
        .out_vvalid (out_vvalid),
        .out_last   (out_last),
        .out_bad    (out_bad)
    );

    // pack result word, upper bits zero
    assign m_tdata = {6'd0, out_vertex, out_degree, out_edge};
    assign m_tuser = {out_bad, out_vvalid};
    assign m_tlast = out_last;

endmodule
